@@ rtl/ftrm_pkg.sv @@
// Package for the fan tachometer speed monitor: shared types and constants.
// Used by the divider unit and the top level; depends on nothing else.
package ftrm_pkg;

	localparam int NUM_W   = 32;
	localparam int DEN_W   = 36;
	localparam int QUOT_W  = 32;
	localparam int RPM_W   = 16;
	localparam int SUM_W   = 19;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [RPM_W-1:0] RPM_MAX       = 16'hFFFF;
	localparam logic [15:0]      MS_PER_MINUTE = 16'd60000;

	// floor(x / 5) == (x * 838861) >> 22 for every x below 2**22.
	localparam logic [19:0] RECIP5       = 20'd838861;
	localparam int          RECIP5_SHIFT = 22;

	localparam logic [15:0] MIN_GAP_RST = 16'd2500;
	localparam logic [15:0] WINDOW_RST  = 16'd1000;
	localparam logic [3:0]  PPR_RST     = 4'd4;
	localparam logic [15:0] FLOOR_RST   = 16'd500;
	localparam logic [15:0] STEP_RST    = 16'd50;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PPR     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STEP    = 3'd4;

	localparam logic CMD_EDGE = 1'b0;
	localparam logic CMD_POLL = 1'b1;

	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  num;
		logic [DEN_W-1:0]  den;
	} ftrm_div_req_t;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
	} ftrm_div_rsp_t;

endpackage

@@ rtl/ftrm_req_if.sv @@
// Request channel of the fan tachometer speed monitor: valid/ready plus item fields.
// Stands alone; used by the top level.
interface ftrm_req_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [31:0] edge_time_us;
	logic [31:0] poll_time_ms;

	modport source (output valid, output cmd, output edge_time_us, output poll_time_ms,
		input ready);
	modport sink (input valid, input cmd, input edge_time_us, input poll_time_ms,
		output ready);
endinterface

@@ rtl/ftrm_res_if.sv @@
// Result channel of the fan tachometer speed monitor: valid/ready plus result fields.
// Stands alone; used by the top level.
interface ftrm_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] rpm;
	logic        measured;
	logic        pulse_accepted;

	modport source (output valid, output rpm, output measured, output pulse_accepted,
		input ready);
	modport sink (input valid, input rpm, input measured, input pulse_accepted,
		output ready);
endinterface

@@ rtl/fan_tacho_rpm_monitor.sv @@
// Fan tachometer speed monitor, top level: sequencer, state and configuration.
// Depends on ftrm_pkg, ftrm_req_if, ftrm_res_if and the shared divider ftrm_div.
//
// Usage: every request on the item channel is either a tacho rising edge
// (cmd low, edge_time_us valid) or a speed poll (cmd high, poll_time_ms valid).
// Each request yields exactly one result on the result channel, carrying the
// current smoothed speed and the flags measured and pulse_accepted.
// An edge is accepted, checked in the evaluation step and its result loaded.
// A poll that closes a window is accepted and then passes through the window
// check, the operand products, the shared one-bit-per-cycle divider and the
// hand-over of its quotient, spike limiting, the divide by five and the
// result load.
// A poll that arrives before the window has run out goes from the window check to the result load.
// The block works on one request at a time and lowers ready meanwhile.
// The result sits in an output register, so the next request is accepted
// while an earlier result still waits; if the receiver stalls, the block
// finishes its current request and then waits until the output register is
// free before loading the new result.
// Reset clears all speed state and the window, loads the default settings,
// and leaves both channels empty. Configuration writes are expected only
// while the block is idle.
module fan_tacho_rpm_monitor import ftrm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	ftrm_req_if.sink              item,
	ftrm_res_if.source            result
);

	// Sequencer states.
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EVAL   = 3'd1;
	localparam logic [2:0] ST_MUL    = 3'd2;
	localparam logic [2:0] ST_DIV    = 3'd3;
	localparam logic [2:0] ST_LIMIT  = 3'd4;
	localparam logic [2:0] ST_SCALE  = 3'd5;
	localparam logic [2:0] ST_FINISH = 3'd6;

	logic [2:0] state_q;

	// Configuration registers.
	logic [15:0] min_gap_q;
	logic [15:0] window_q;
	logic [3:0]  ppr_q;
	logic [15:0] floor_q;
	logic [15:0] step_q;

	// Speed measurement state.
	logic [31:0]      last_edge_q;
	logic [15:0]      tally_q;
	logic [31:0]      win_start_q;
	logic [RPM_W-1:0] smoothed_q;

	// The request being worked on and intermediate values.
	logic             cmd_q;
	logic [31:0]      edge_time_q;
	logic [31:0]      poll_time_q;
	logic [31:0]      elapsed_q;
	logic [RPM_W-1:0] raw_q;
	logic [SUM_W-1:0] sum_q;
	logic             measured_q;
	logic             pulse_q;

	// Output register.
	logic             res_valid_q;
	logic [RPM_W-1:0] res_rpm_q;
	logic             res_measured_q;
	logic             res_pulse_q;

	ftrm_div_req_t div_req;
	ftrm_div_rsp_t div_rsp;

	logic             accept;
	logic             out_free;
	logic [31:0]      gap;
	logic [31:0]      elapsed;
	logic [31:0]      win_eff;
	logic [3:0]       ppr_eff;
	logic [NUM_W-1:0] num_prod;
	logic [DEN_W-1:0] den_prod;
	logic [RPM_W-1:0] raw_sat;
	logic [17:0]      two_raw;
	logic [17:0]      three_old;
	logic [16:0]      step_sum;
	logic [RPM_W-1:0] raw_lim;
	logic             spike;
	logic [RPM_W-1:0] raw_used;
	logic [SUM_W-1:0] sum;
	logic [38:0]      scale_prod;
	logic [RPM_W-1:0] new_rpm;

	assign accept   = item.valid && item.ready;
	assign out_free = !res_valid_q || result.ready;
	assign item.ready = (state_q == ST_IDLE);

	// Edge qualification and window check, both with wrapping subtraction.
	assign gap     = edge_time_q - last_edge_q;
	assign elapsed = poll_time_q - win_start_q;
	assign win_eff = (window_q == '0) ? 32'd1 : {16'b0, window_q};
	assign ppr_eff = (ppr_q == '0) ? 4'd1 : ppr_q;

	// Operands of the speed division: pulses * 60000 over ppr * elapsed.
	// The numerator stays below 2**32 because the tally is at most 16 bits.
	assign num_prod = {16'b0, tally_q} * {16'b0, MS_PER_MINUTE};
	assign den_prod = {32'b0, ppr_eff} * {4'b0, elapsed_q};

	assign div_req.start = (state_q == ST_MUL);
	assign div_req.num   = num_prod;
	assign div_req.den   = den_prod;

	assign raw_sat = (div_rsp.quot[QUOT_W-1:RPM_W] != '0) ? RPM_MAX : div_rsp.quot[RPM_W-1:0];

	// Spike limiting: a raw speed above 1.5 times the old speed is clamped to
	// old plus the allowed step, but only once the old speed is above the floor.
	assign two_raw   = {1'b0, raw_q, 1'b0};
	assign three_old = {2'b0, smoothed_q} + {1'b0, smoothed_q, 1'b0};
	assign step_sum  = {1'b0, smoothed_q} + {1'b0, step_q};
	assign raw_lim   = step_sum[16] ? RPM_MAX : step_sum[15:0];
	assign spike     = (smoothed_q > floor_q) && (two_raw > three_old);
	assign raw_used  = spike ? raw_lim : raw_q;
	assign sum       = {1'b0, smoothed_q, 2'b0} + {3'b0, raw_used};

	// Smoothing: (4*old + raw) / 5 through a reciprocal multiply. The sum is
	// at most five times the speed range, so the quotient fits 16 bits.
	assign scale_prod = {20'b0, sum_q} * {19'b0, RECIP5};
	assign new_rpm    = scale_prod[RECIP5_SHIFT +: RPM_W];

	ftrm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_gap_q <= MIN_GAP_RST;
			window_q  <= WINDOW_RST;
			ppr_q     <= PPR_RST;
			floor_q   <= FLOOR_RST;
			step_q    <= STEP_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_MIN_GAP: min_gap_q <= cfg_data;
				REG_WINDOW:  window_q  <= cfg_data;
				REG_PPR:     ppr_q     <= cfg_data[3:0];
				REG_FLOOR:   floor_q   <= cfg_data;
				REG_STEP:    step_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer and measurement state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_edge_q <= '0;
			tally_q     <= '0;
			win_start_q <= '0;
			smoothed_q  <= '0;
			measured_q  <= 1'b0;
			pulse_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					measured_q <= 1'b0;
					pulse_q    <= 1'b0;
					if (cmd_q == CMD_EDGE) begin
						if (gap > {16'b0, min_gap_q}) begin
							if (tally_q != RPM_MAX) begin
								tally_q <= tally_q + 1'b1;
							end
							last_edge_q <= edge_time_q;
							pulse_q     <= 1'b1;
						end
						state_q <= ST_FINISH;
					end else if (elapsed >= win_eff) begin
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_LIMIT;
					end
				end
				ST_LIMIT: begin
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					smoothed_q  <= new_rpm;
					tally_q     <= '0;
					win_start_q <= poll_time_q;
					measured_q  <= 1'b1;
					state_q     <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request fields and intermediate values.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q       <= item.cmd;
			edge_time_q <= item.edge_time_us;
			poll_time_q <= item.poll_time_ms;
		end
		if (state_q == ST_EVAL) begin
			elapsed_q <= elapsed;
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			raw_q <= raw_sat;
		end
		if (state_q == ST_LIMIT) begin
			sum_q <= sum;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			res_rpm_q      <= smoothed_q;
			res_measured_q <= measured_q;
			res_pulse_q    <= pulse_q;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.rpm            = res_rpm_q;
	assign result.measured       = res_measured_q;
	assign result.pulse_accepted = res_pulse_q;

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV)
		else $error("divider finished outside the division step");
	a_speed_update: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(smoothed_q) |-> $past(state_q) == ST_SCALE)
		else $error("smoothed speed changed outside the smoothing step");
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(res_measured_q && res_pulse_q))
		else $error("result flags measured and pulse_accepted both set");
	a_poll_no_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |-> cmd_q == CMD_POLL)
		else $error("speed division started for an edge request");

endmodule

@@ rtl/ftrm_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on ftrm_pkg for operand widths and the request/response structs.
module ftrm_div import ftrm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  ftrm_div_req_t req,
	output ftrm_div_rsp_t rsp
);

	localparam int STEPS = QUOT_W;
	localparam int CNT_W = $clog2(STEPS);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [QUOT_W-1:0] quot_q;

	logic [DEN_W:0] shifted;
	logic [DEN_W:0] diff;
	logic           fits;

	assign shifted = {rem_q, quot_q[QUOT_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The remainder stays below the divisor, so it always fits DEN_W bits.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= '0;
			den_q  <= req.den;
			quot_q <= req.num;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
			quot_q <= {quot_q[QUOT_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> busy_q)
		else $error("divider did not start");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q)
		else $error("divider done without a running division");

endmodule

@@ tb/tb_top.sv @@
// Testbench for the fan tachometer speed monitor: a directed request table and random
// traffic, checked against expected results in the table or an in-bench speed model.
// Depends on ftrm_pkg, ftrm_req_if, ftrm_res_if and fan_tacho_rpm_monitor.
`timescale 1ns / 1ps

module tb_top import ftrm_pkg::*; ();

	// Quiet cycles before a register write, so that the divider has finished.
	localparam int SETTLE_CYCLES   = 50;
	// Cycles with no handshake on either channel before the run is declared hung.
	localparam int WATCHDOG_CYCLES = 5000;
	localparam int ITEMS_PER_SET   = 78;

	// One result of the block, in port order.
	typedef struct packed {
		logic [RPM_W-1:0] rpm;
		logic             measured;
		logic             pulse_accepted;
	} speed_res_t;

	typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

	// One row of the directed table: either a request or a register write.
	// A row with typed set carries its expected result; the others use the model.
	typedef struct packed {
		row_kind_t             kind;
		logic                  cmd;
		logic [31:0]           t_us;
		logic [31:0]           t_ms;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		logic                  typed;
		speed_res_t            want;
	} plan_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ftrm_req_if req_ch();
	ftrm_res_if res_ch();

	fan_tacho_rpm_monitor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (req_ch),
		.result    (res_ch)
	);

	// Settings as the model sees them; they track every register write.
	logic [15:0] min_gap_cfg;
	logic [15:0] window_cfg;
	logic [3:0]  ppr_cfg;
	logic [15:0] floor_cfg;
	logic [15:0] step_cfg;

	// Speed state of the model, mirroring what the block keeps.
	logic [31:0] last_edge_us;
	logic [15:0] counted_pulses;
	logic [31:0] window_open_ms;
	logic [15:0] speed_avg;

	// Results still owed by the block, oldest first.
	speed_res_t speed_q[$];
	speed_res_t owed_head;

	plan_row_t plan[$];

	int mismatch_count;
	int send_idle_pct;
	int recv_idle_pct;
	int quiet_cycles;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic logic [63:0] cap_rpm(input logic [63:0] v);
		return (v > 64'(RPM_MAX)) ? 64'(RPM_MAX) : v;
	endfunction

	// Advances the model by one request and returns the result the block owes for it.
	function automatic speed_res_t advance_tacho(input logic cmd, input logic [31:0] t_us,
		input logic [31:0] t_ms);
		speed_res_t  r;
		logic [31:0] gap_us;
		logic [31:0] elapsed;
		logic [31:0] eff_win;
		logic [63:0] ppr;
		logic [63:0] pulse_num;
		logic [63:0] pulse_den;
		logic [63:0] raw;
		logic [63:0] old;
		r = '0;
		if (cmd == CMD_EDGE) begin
			// The gap uses wrapping subtraction, so the timer may roll over freely.
			gap_us = t_us - last_edge_us;
			if (gap_us > {16'd0, min_gap_cfg}) begin
				if (counted_pulses != RPM_MAX)
					counted_pulses = counted_pulses + 16'd1;
				last_edge_us     = t_us;
				r.pulse_accepted = 1'b1;
			end
		end else begin
			elapsed = t_ms - window_open_ms;
			eff_win = (window_cfg == 16'd0) ? 32'd1 : {16'd0, window_cfg};
			if (elapsed >= eff_win) begin
				ppr       = (ppr_cfg == 4'd0) ? 64'd1 : {60'd0, ppr_cfg};
				pulse_num = {48'd0, counted_pulses} * 64'd60000;
				pulse_den = ppr * {32'd0, elapsed};
				raw       = cap_rpm(pulse_num / pulse_den);
				old       = {48'd0, speed_avg};
				// A reading above one and a half times the old speed is treated as a
				// spike once the fan is above the floor; it may only rise by the step.
				if (old > {48'd0, floor_cfg} && 64'd2 * raw > 64'd3 * old)
					raw = cap_rpm(old + {48'd0, step_cfg});
				speed_avg      = 16'(cap_rpm((64'd4 * old + raw) / 64'd5));
				counted_pulses = 16'd0;
				window_open_ms = t_ms;
				r.measured     = 1'b1;
			end
		end
		r.rpm = speed_avg;
		return r;
	endfunction

	function automatic plan_row_t plan_item(input logic cmd, input logic [31:0] t_us,
		input logic [31:0] t_ms);
		plan_row_t row;
		row      = '0;
		row.kind = ROW_ITEM;
		row.cmd  = cmd;
		row.t_us = t_us;
		row.t_ms = t_ms;
		return row;
	endfunction

	function automatic plan_row_t plan_checked(input logic cmd, input logic [31:0] t_us,
		input logic [31:0] t_ms, input logic [15:0] rpm, input logic measured,
		input logic accepted);
		plan_row_t row;
		row                     = plan_item(cmd, t_us, t_ms);
		row.typed               = 1'b1;
		row.want.rpm            = rpm;
		row.want.measured       = measured;
		row.want.pulse_accepted = accepted;
		return row;
	endfunction

	function automatic plan_row_t plan_write(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		plan_row_t row;
		row         = '0;
		row.kind    = ROW_WRITE;
		row.reg_idx = idx;
		row.reg_val = val;
		return row;
	endfunction

	// Mostly typical values, with both ends of the register range mixed in.
	function automatic logic [15:0] pick_level(input int typical_max);
		unique case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom);
			default: return 16'($urandom_range(0, typical_max));
		endcase
	endfunction

	// Stops sending, waits for every owed result, then lets the block go quiet.
	task automatic settle_idle();
		req_ch.valid <= 1'b0;
		while (speed_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register writes happen only on an idle block, so each one settles first.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		settle_idle();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		unique case (idx)
			REG_MIN_GAP: min_gap_cfg = val;
			REG_WINDOW:  window_cfg  = val;
			REG_PPR:     ppr_cfg     = val[3:0];
			REG_FLOOR:   floor_cfg   = val;
			REG_STEP:    step_cfg    = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic pick_settings();
		write_reg(REG_MIN_GAP, pick_level(3000));
		write_reg(REG_WINDOW, pick_level(60));
		write_reg(REG_PPR, 16'($urandom_range(0, 15)));
		write_reg(REG_FLOOR, pick_level(4000));
		write_reg(REG_STEP, pick_level(500));
	endtask

	// Offers one request, holds it until the block takes it, and records what is owed.
	// Valid stays high between back-to-back requests; it drops only for a gap or while the bench settles.
	task automatic send_request(input logic cmd, input logic [31:0] t_us,
		input logic [31:0] t_ms, input logic typed, input speed_res_t typed_want);
		speed_res_t predicted;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct);
		end
		req_ch.valid        <= 1'b1;
		req_ch.cmd          <= cmd;
		req_ch.edge_time_us <= t_us;
		req_ch.poll_time_ms <= t_ms;
		do
			@(posedge clk);
		while (!req_ch.ready);
		predicted = advance_tacho(cmd, t_us, t_ms);
		speed_q.push_back(typed ? typed_want : predicted);
	endtask

	// Result side: every accepted result is matched against the oldest owed one.
	// The receiver stalls at random in the same block.
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (speed_q.size() == 0) begin
				$error("result with no request pending: rpm %0d measured %0d pulse_accepted %0d",
					res_ch.rpm, res_ch.measured, res_ch.pulse_accepted);
				mismatch_count++;
			end else begin
				owed_head = speed_q.pop_front();
				if (res_ch.rpm !== owed_head.rpm) begin
					$error("rpm: expected %0d, got %0d", owed_head.rpm, res_ch.rpm);
					mismatch_count++;
				end
				if (res_ch.measured !== owed_head.measured) begin
					$error("measured: expected %0d, got %0d", owed_head.measured,
						res_ch.measured);
					mismatch_count++;
				end
				if (res_ch.pulse_accepted !== owed_head.pulse_accepted) begin
					$error("pulse_accepted: expected %0d, got %0d", owed_head.pulse_accepted,
						res_ch.pulse_accepted);
					mismatch_count++;
				end
			end
		end
		res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Watchdog: a long stretch with no handshake on either channel means a hang.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	initial begin
		int          ph;
		int          sub;
		int          roll;
		int          poll_pct;
		logic        cmd;
		logic [31:0] tu;
		logic [31:0] tm;
		logic [31:0] cur_us;
		logic [31:0] cur_ms;
		logic [31:0] eff_win;
		logic        noise;

		// Every input is known from time zero, when reset is asserted.
		arst_n              = 1'b0;
		cfg_wr_en           = 1'b0;
		cfg_index           = REG_MIN_GAP;
		cfg_data            = '0;
		req_ch.valid        = 1'b0;
		req_ch.cmd          = CMD_EDGE;
		req_ch.edge_time_us = '0;
		req_ch.poll_time_ms = '0;
		res_ch.ready        = 1'b0;
		mismatch_count      = 0;
		quiet_cycles        = 0;
		send_idle_pct       = 0;
		recv_idle_pct       = 0;

		// Model state after reset: default settings, all speed state cleared.
		min_gap_cfg    = MIN_GAP_RST;
		window_cfg     = WINDOW_RST;
		ppr_cfg        = PPR_RST;
		floor_cfg      = FLOOR_RST;
		step_cfg       = STEP_RST;
		last_edge_us   = '0;
		counted_pulses = '0;
		window_open_ms = '0;
		speed_avg      = '0;

		// Directed table. The first rows run on the reset settings: a poll at time
		// zero is still inside the window, an edge at time zero and one exactly at
		// the minimum gap are rejected, one microsecond more is counted, and edges
		// across the timer rollover (and even backwards) count by wrapping gap.
		plan.push_back(plan_checked(CMD_POLL, 32'd0, 32'd0, 16'd0, 1'b0, 1'b0));
		plan.push_back(plan_checked(CMD_EDGE, 32'd0, 32'd0, 16'd0, 1'b0, 1'b0));
		plan.push_back(plan_checked(CMD_EDGE, 32'd2500, 32'd0, 16'd0, 1'b0, 1'b0));
		plan.push_back(plan_checked(CMD_EDGE, 32'd2501, 32'd0, 16'd0, 1'b0, 1'b1));
		plan.push_back(plan_checked(CMD_EDGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 1'b0,
			1'b1));
		plan.push_back(plan_checked(CMD_EDGE, 32'd2500, 32'd0, 16'd0, 1'b0, 1'b1));
		plan.push_back(plan_checked(CMD_EDGE, 32'd2499, 32'd0, 16'd0, 1'b0, 1'b1));
		// One millisecond short of the window, then exactly on it.
		plan.push_back(plan_checked(CMD_POLL, 32'hFFFF_FFFF, 32'd999, 16'd0, 1'b0, 1'b0));
		plan.push_back(plan_item(CMD_POLL, 32'd0, 32'd1000));
		// A zero window behaves as one millisecond, zero pulses per revolution as
		// one, and a zero gap rejects only an edge with the very same timestamp.
		plan.push_back(plan_write(REG_WINDOW, 16'd0));
		plan.push_back(plan_write(REG_PPR, 16'd0));
		plan.push_back(plan_write(REG_MIN_GAP, 16'd0));
		plan.push_back(plan_item(CMD_EDGE, 32'd1, 32'd0));
		plan.push_back(plan_item(CMD_EDGE, 32'd1, 32'd0));
		plan.push_back(plan_item(CMD_EDGE, 32'd2, 32'd0));
		plan.push_back(plan_item(CMD_POLL, 32'd0, 32'd1000));
		// Two pulses in one millisecond overflow the raw speed; the old speed is
		// still below the floor, so no spike limit yet.
		plan.push_back(plan_item(CMD_POLL, 32'd0, 32'd1001));
		// Now above the floor: the next overflowing reading is a spike.
		plan.push_back(plan_item(CMD_EDGE, 32'd3, 32'd0));
		plan.push_back(plan_item(CMD_EDGE, 32'd4, 32'd0));
		plan.push_back(plan_item(CMD_POLL, 32'd0, 32'd1002));
		// Largest step from a zero floor: the limited speed saturates again.
		plan.push_back(plan_write(REG_STEP, 16'hFFFF));
		plan.push_back(plan_write(REG_FLOOR, 16'd0));
		plan.push_back(plan_item(CMD_EDGE, 32'd5, 32'd0));
		plan.push_back(plan_item(CMD_EDGE, 32'd6, 32'd0));
		plan.push_back(plan_item(CMD_POLL, 32'd0, 32'd1003));
		// Every register at its top value: gap and window boundaries, a huge
		// elapsed time, and a poll timer that wraps around.
		plan.push_back(plan_write(REG_FLOOR, 16'hFFFF));
		plan.push_back(plan_write(REG_PPR, 16'hF));
		plan.push_back(plan_write(REG_WINDOW, 16'hFFFF));
		plan.push_back(plan_write(REG_MIN_GAP, 16'hFFFF));
		plan.push_back(plan_item(CMD_EDGE, 32'h0001_0005, 32'd0));
		plan.push_back(plan_item(CMD_EDGE, 32'h0001_0006, 32'd0));
		plan.push_back(plan_item(CMD_POLL, 32'd0, 32'd66537));
		plan.push_back(plan_item(CMD_POLL, 32'd0, 32'hFFFF_FFFF));
		plan.push_back(plan_item(CMD_POLL, 32'd0, 32'h0000_FFFE));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE)
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			else
				send_request(plan[i].cmd, plan[i].t_us, plan[i].t_ms, plan[i].typed,
					plan[i].want);
		end

		// Random part in three idling phases, each with several register settings.
		// Most requests follow a running timeline (edges spaced around the minimum
		// gap, polls around the window) so that windows close with real counts;
		// a few are noise with arbitrary timestamps.
		for (ph = 0; ph < 3; ph++) begin
			unique case (ph)
				0: begin
					send_idle_pct = 34;
					recv_idle_pct = 51;
				end
				1: begin
					send_idle_pct = 51;
					recv_idle_pct = 34;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (sub = 0; sub < 3; sub++) begin
				pick_settings();
				cur_us   = last_edge_us;
				cur_ms   = window_open_ms;
				poll_pct = $urandom_range(10, 45);
				repeat (ITEMS_PER_SET) begin
					roll  = $urandom_range(0, 99);
					noise = 1'b0;
					if (roll < 6) begin
						noise = 1'b1;
						cmd   = 1'($urandom_range(0, 1));
						tu    = $urandom;
						tm    = $urandom;
					end else if (roll < 6 + poll_pct) begin
						eff_win = (window_cfg == 16'd0) ? 32'd1 : {16'd0, window_cfg};
						cur_ms  = cur_ms + 32'($urandom_range(0, 2 * eff_win));
						cmd     = CMD_POLL;
						tu      = $urandom;
						tm      = cur_ms;
					end else begin
						// A quarter of the edges land inside the gap and should bounce.
						if ($urandom_range(0, 3) == 0)
							cur_us = cur_us + 32'($urandom_range(0, min_gap_cfg));
						else
							cur_us = cur_us + {16'd0, min_gap_cfg} +
								32'($urandom_range(1, 3000));
						cmd = CMD_EDGE;
						tu  = cur_us;
						tm  = $urandom;
					end
					send_request(cmd, tu, tm, 1'b0, '0);
					// After noise, pick the timeline up again where the block stands.
					if (noise) begin
						cur_us = last_edge_us;
						cur_ms = window_open_ms;
					end
					// Now and then the sender holds off until the block has answered
					// everything it owes.
					if ($urandom_range(0, 99) == 0)
						settle_idle();
				end
			end
		end

		settle_idle();
		if (mismatch_count == 0 && speed_q.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/ftrm_pkg.sv
rtl/ftrm_req_if.sv
rtl/ftrm_res_if.sv
rtl/ftrm_div.sv
rtl/fan_tacho_rpm_monitor.sv
tb/tb_top.sv
